// File: hdl/trs_to_model_matrix_core_defines.svh
// Assertion macros for the TRS to model matrix core
`ifndef TRS_TO_MODEL_MATRIX_CORE_DEFINES_SVH
`define TRS_TO_MODEL_MATRIX_CORE_DEFINES_SVH

// Check a property on every rising edge of clk outside reset
`define TRS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("trs check failed");

// Check that cons holds in the cycle after ante
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trs check failed");

`endif

// File: hdl/trs_pkg.sv
// Types and constants shared by the TRS to model matrix core
package trs_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned QUAT_W = 16;
	localparam int unsigned PROD_W = 2 * QUAT_W;
	localparam int unsigned TERM_W = PROD_W + 3;
	localparam int unsigned FRAC_W = 14;
	localparam int unsigned ROT_W  = TERM_W - FRAC_W;
	localparam int unsigned MUL_W  = ROT_W + POS_W;
	localparam int unsigned SHR_W  = MUL_W - FRAC_W;
	localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(1) <<< 28;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [POS_W-1:0]  scale_x;
		logic signed [POS_W-1:0]  scale_y;
		logic signed [POS_W-1:0]  scale_z;
	} trs_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] c0_r0;
		logic signed [POS_W-1:0] c0_r1;
		logic signed [POS_W-1:0] c0_r2;
		logic signed [POS_W-1:0] c1_r0;
		logic signed [POS_W-1:0] c1_r1;
		logic signed [POS_W-1:0] c1_r2;
		logic signed [POS_W-1:0] c2_r0;
		logic signed [POS_W-1:0] c2_r1;
		logic signed [POS_W-1:0] c2_r2;
		logic signed [POS_W-1:0] c3_r0;
		logic signed [POS_W-1:0] c3_r1;
		logic signed [POS_W-1:0] c3_r2;
	} trs_out_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} trs_adv_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] xx;
		logic signed [PROD_W-1:0] yy;
		logic signed [PROD_W-1:0] zz;
		logic signed [PROD_W-1:0] xy;
		logic signed [PROD_W-1:0] xz;
		logic signed [PROD_W-1:0] yz;
		logic signed [PROD_W-1:0] wx;
		logic signed [PROD_W-1:0] wy;
		logic signed [PROD_W-1:0] wz;
		logic signed [POS_W-1:0]  scale_x;
		logic signed [POS_W-1:0]  scale_y;
		logic signed [POS_W-1:0]  scale_z;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} trs_prod_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] c0r0;
		logic signed [ROT_W-1:0] c0r1;
		logic signed [ROT_W-1:0] c0r2;
		logic signed [ROT_W-1:0] c1r0;
		logic signed [ROT_W-1:0] c1r1;
		logic signed [ROT_W-1:0] c1r2;
		logic signed [ROT_W-1:0] c2r0;
		logic signed [ROT_W-1:0] c2r1;
		logic signed [ROT_W-1:0] c2r2;
		logic signed [POS_W-1:0] scale_x;
		logic signed [POS_W-1:0] scale_y;
		logic signed [POS_W-1:0] scale_z;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} trs_rot_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] c0r0;
		logic signed [MUL_W-1:0] c0r1;
		logic signed [MUL_W-1:0] c0r2;
		logic signed [MUL_W-1:0] c1r0;
		logic signed [MUL_W-1:0] c1r1;
		logic signed [MUL_W-1:0] c1r2;
		logic signed [MUL_W-1:0] c2r0;
		logic signed [MUL_W-1:0] c2r1;
		logic signed [MUL_W-1:0] c2r2;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} trs_mul_t;

endpackage

// File: hdl/trs_in_if.sv
// Input channel carrying one position, rotation and scale transaction
interface trs_in_if;
	logic             valid;
	logic             ready;
	trs_pkg::trs_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/trs_out_if.sv
// Output channel carrying one model matrix transaction
interface trs_out_if;
	logic              valid;
	logic              ready;
	trs_pkg::trs_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/trs_quat_prod.sv
// Stage 1: pairwise quaternion products
module trs_quat_prod (
	input  logic               clk,
	input  trs_pkg::trs_adv_t  adv,
	input  trs_pkg::trs_in_t   item_data,
	output trs_pkg::trs_prod_t prod_s1
);
	import trs_pkg::*;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1.xx      <= item_data.quat_x * item_data.quat_x;
			prod_s1.yy      <= item_data.quat_y * item_data.quat_y;
			prod_s1.zz      <= item_data.quat_z * item_data.quat_z;
			prod_s1.xy      <= item_data.quat_x * item_data.quat_y;
			prod_s1.xz      <= item_data.quat_x * item_data.quat_z;
			prod_s1.yz      <= item_data.quat_y * item_data.quat_z;
			prod_s1.wx      <= item_data.quat_w * item_data.quat_x;
			prod_s1.wy      <= item_data.quat_w * item_data.quat_y;
			prod_s1.wz      <= item_data.quat_w * item_data.quat_z;
			prod_s1.scale_x <= item_data.scale_x;
			prod_s1.scale_y <= item_data.scale_y;
			prod_s1.scale_z <= item_data.scale_z;
			prod_s1.pos_x   <= item_data.pos_x;
			prod_s1.pos_y   <= item_data.pos_y;
			prod_s1.pos_z   <= item_data.pos_z;
		end
	end
endmodule

// File: hdl/trs_rot_terms.sv
// Stage 2: rotation matrix terms, truncated to Q7.14
module trs_rot_terms (
	input  logic               clk,
	input  trs_pkg::trs_adv_t  adv,
	input  trs_pkg::trs_prod_t prod_s1,
	output trs_pkg::trs_rot_t  rot_s2
);
	import trs_pkg::*;

	logic signed [TERM_W-1:0] t00, t01, t02, t10, t11, t12, t20, t21, t22;

	always_comb begin
		t00 = ONE_Q28 - ((TERM_W'(prod_s1.yy) + TERM_W'(prod_s1.zz)) <<< 1);
		t01 = (TERM_W'(prod_s1.xy) + TERM_W'(prod_s1.wz)) <<< 1;
		t02 = (TERM_W'(prod_s1.xz) - TERM_W'(prod_s1.wy)) <<< 1;
		t10 = (TERM_W'(prod_s1.xy) - TERM_W'(prod_s1.wz)) <<< 1;
		t11 = ONE_Q28 - ((TERM_W'(prod_s1.xx) + TERM_W'(prod_s1.zz)) <<< 1);
		t12 = (TERM_W'(prod_s1.yz) + TERM_W'(prod_s1.wx)) <<< 1;
		t20 = (TERM_W'(prod_s1.xz) + TERM_W'(prod_s1.wy)) <<< 1;
		t21 = (TERM_W'(prod_s1.yz) - TERM_W'(prod_s1.wx)) <<< 1;
		t22 = ONE_Q28 - ((TERM_W'(prod_s1.xx) + TERM_W'(prod_s1.yy)) <<< 1);
	end

	// drop the low fraction bits: floor to Q7.14
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			rot_s2.c0r0    <= t00[TERM_W-1:FRAC_W];
			rot_s2.c0r1    <= t01[TERM_W-1:FRAC_W];
			rot_s2.c0r2    <= t02[TERM_W-1:FRAC_W];
			rot_s2.c1r0    <= t10[TERM_W-1:FRAC_W];
			rot_s2.c1r1    <= t11[TERM_W-1:FRAC_W];
			rot_s2.c1r2    <= t12[TERM_W-1:FRAC_W];
			rot_s2.c2r0    <= t20[TERM_W-1:FRAC_W];
			rot_s2.c2r1    <= t21[TERM_W-1:FRAC_W];
			rot_s2.c2r2    <= t22[TERM_W-1:FRAC_W];
			rot_s2.scale_x <= prod_s1.scale_x;
			rot_s2.scale_y <= prod_s1.scale_y;
			rot_s2.scale_z <= prod_s1.scale_z;
			rot_s2.pos_x   <= prod_s1.pos_x;
			rot_s2.pos_y   <= prod_s1.pos_y;
			rot_s2.pos_z   <= prod_s1.pos_z;
		end
	end
endmodule

// File: hdl/trs_scale_mul.sv
// Stages 3 and 4: scale multiply, then shift and saturate to Q16.16
module trs_scale_mul (
	input  logic              clk,
	input  trs_pkg::trs_adv_t adv,
	input  trs_pkg::trs_rot_t rot_s2,
	output trs_pkg::trs_out_t res_s4
);
	import trs_pkg::*;

	trs_mul_t mul_s3;

	function automatic logic signed [POS_W-1:0] sat_q16(input logic signed [MUL_W-1:0] m);
		logic signed [SHR_W-1:0] sh;
		logic signed [POS_W-1:0] r;
		sh = m[MUL_W-1:FRAC_W];
		if (sh > $signed(SHR_W'({1'b0, {(POS_W-1){1'b1}}})))
			r = {1'b0, {(POS_W-1){1'b1}}};
		else if (sh < $signed(SHR_W'({{(SHR_W-POS_W){1'b1}}, 1'b1, {(POS_W-1){1'b0}}})))
			r = {1'b1, {(POS_W-1){1'b0}}};
		else
			r = sh[POS_W-1:0];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			mul_s3.c0r0  <= $signed(rot_s2.c0r0) * $signed(rot_s2.scale_x);
			mul_s3.c0r1  <= $signed(rot_s2.c0r1) * $signed(rot_s2.scale_x);
			mul_s3.c0r2  <= $signed(rot_s2.c0r2) * $signed(rot_s2.scale_x);
			mul_s3.c1r0  <= $signed(rot_s2.c1r0) * $signed(rot_s2.scale_y);
			mul_s3.c1r1  <= $signed(rot_s2.c1r1) * $signed(rot_s2.scale_y);
			mul_s3.c1r2  <= $signed(rot_s2.c1r2) * $signed(rot_s2.scale_y);
			mul_s3.c2r0  <= $signed(rot_s2.c2r0) * $signed(rot_s2.scale_z);
			mul_s3.c2r1  <= $signed(rot_s2.c2r1) * $signed(rot_s2.scale_z);
			mul_s3.c2r2  <= $signed(rot_s2.c2r2) * $signed(rot_s2.scale_z);
			mul_s3.pos_x <= rot_s2.pos_x;
			mul_s3.pos_y <= rot_s2.pos_y;
			mul_s3.pos_z <= rot_s2.pos_z;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			res_s4.c0_r0 <= sat_q16(mul_s3.c0r0);
			res_s4.c0_r1 <= sat_q16(mul_s3.c0r1);
			res_s4.c0_r2 <= sat_q16(mul_s3.c0r2);
			res_s4.c1_r0 <= sat_q16(mul_s3.c1r0);
			res_s4.c1_r1 <= sat_q16(mul_s3.c1r1);
			res_s4.c1_r2 <= sat_q16(mul_s3.c1r2);
			res_s4.c2_r0 <= sat_q16(mul_s3.c2r0);
			res_s4.c2_r1 <= sat_q16(mul_s3.c2r1);
			res_s4.c2_r2 <= sat_q16(mul_s3.c2r2);
			res_s4.c3_r0 <= mul_s3.pos_x;
			res_s4.c3_r1 <= mul_s3.pos_y;
			res_s4.c3_r2 <= mul_s3.pos_z;
		end
	end
endmodule

// File: hdl/trs_to_model_matrix_core.sv
// Top level of the TRS to model matrix core
//
// Builds the upper three rows of the model matrix T*R*S from a position,
// a Q2.14 rotation quaternion (taken as unit length, not normalized) and a
// per-axis Q16.16 scale. Four register stages: quaternion products, rotation
// terms floored to Q7.14, the 21x32 scale multiply, then shift and saturate
// into the output register. One transaction enters per cycle unless a stall
// on the output has filled every stage; a stall holds only the stages that
// are full, so bubbles ahead of the stall still fill.
module trs_to_model_matrix_core (
	input  logic            clk,
	input  logic            arst_n,
	trs_in_if.sink          item,
	trs_out_if.source       result
);
	import trs_pkg::*;

	trs_adv_t  adv;
	logic      v_s1, v_s2, v_s3, v_s4;
	trs_prod_t prod_s1;
	trs_rot_t  rot_s2;
	trs_out_t  res_s4;

	always_comb begin
		adv.s4 = !v_s4 || result.ready;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1)
				v_s1 <= item.valid;
			if (adv.s2)
				v_s2 <= v_s1;
			if (adv.s3)
				v_s3 <= v_s2;
			if (adv.s4)
				v_s4 <= v_s3;
		end
	end

	trs_quat_prod u_prod (
		.clk       (clk),
		.adv       (adv),
		.item_data (item.data),
		.prod_s1   (prod_s1)
	);

	trs_rot_terms u_rot (
		.clk     (clk),
		.adv     (adv),
		.prod_s1 (prod_s1),
		.rot_s2  (rot_s2)
	);

	trs_scale_mul u_mul (
		.clk    (clk),
		.adv    (adv),
		.rot_s2 (rot_s2),
		.res_s4 (res_s4)
	);

	assign item.ready   = adv.s1;
	assign result.valid = v_s4;
	assign result.data  = res_s4;
endmodule

// File: hdl/trs_chk.sv
// Port-level checker for the TRS to model matrix core, with its bind
`include "trs_to_model_matrix_core_defines.svh"

module trs_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input trs_pkg::trs_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input trs_pkg::trs_out_t out_data
);
	import trs_pkg::*;

	`TRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TRS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	`TRS_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
	`TRS_ASSERT(a_latency_pos, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> (out_valid && out_data.c3_r0 == $past(in_data.pos_x, 4)))
endmodule

bind trs_to_model_matrix_core trs_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_data   (item.data),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
